// ----- hw/rtl/stbs_pkg.sv -----
// shared types and codes for the sorted table search block
package stbs_pkg;

  // input command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_PROBE,
    ST_DONE
  } state_t;

  // source of the table read address
  typedef enum logic [1:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_INIT_MID,
    ADDR_NEXT_MID
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      write;
    logic      init_bounds;
    logic      probe;
    addr_sel_t addr_sel;
  } stbs_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic key_ge_data;
    logic key_le_data;
    logic more;
  } stbs_status_t;

endpackage

// ----- hw/rtl/sorted_table_binary_search.sv -----
// top level of the sorted table lower-bound search block
//
//   channel   signals                                   direction  transfer when
//   command   start busy command entry_index value      in         start && !busy
//   result    result_valid found match_index            out        result_valid
//   config    config_write config_data                  in         config_write
//
// a table write gives no result; busy stays low
// a search checks the first entry, then the last, then makes p halving probes, p at most
// floor(log2(n)) + 1 for n entries in use, then strobes the result; one table read a cycle
// no entries in use: no checks; key outside the table: no probes; next transfer the cycle after
// rst is synchronous; it clears the state machine and entry_count, not the table
// the receiver cannot stall: result_valid strobes once per result; found and match_index hold until the next search
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: entry_count
  input  logic               config_write,
  input  logic [10:0]        config_data,
  // command transfer
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [9:0]         entry_index,
  input  logic signed [31:0] value,
  // result transfer
  output logic               result_valid,
  output logic               found,
  output logic [9:0]         match_index
);

  // control and status between the state machine and the datapath
  stbs_pkg::stbs_cmd_t    cmd;
  stbs_pkg::stbs_status_t status;

  // sequencer: table writes, or for a search bound checks, halving probes and a result strobe
  stbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // table memory, search bounds, key compare and entry_count register
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_data  (config_data),
    .entry_index  (entry_index),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .found        (found),
    .match_index  (match_index)
  );

endmodule

// ----- hw/rtl/stbs_ctrl.sv -----
// controller state machine for the sorted table search
module stbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  command,
  input  stbs_pkg::stbs_status_t status,
  output stbs_pkg::stbs_cmd_t    cmd,
  output logic                  busy,
  output logic                  result_valid
);

  stbs_pkg::state_t state;
  stbs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stbs_pkg::ST_IDLE: begin
        if (start && command == stbs_pkg::CMD_SEARCH) begin
          state_next = status.count_zero ? stbs_pkg::ST_DONE : stbs_pkg::ST_CHK_FIRST;
        end
      end
      stbs_pkg::ST_CHK_FIRST: begin
        state_next = status.key_ge_data ? stbs_pkg::ST_CHK_LAST : stbs_pkg::ST_DONE;
      end
      stbs_pkg::ST_CHK_LAST: begin
        state_next = status.key_le_data ? stbs_pkg::ST_PROBE : stbs_pkg::ST_DONE;
      end
      stbs_pkg::ST_PROBE: begin
        state_next = status.more ? stbs_pkg::ST_PROBE : stbs_pkg::ST_DONE;
      end
      stbs_pkg::ST_DONE: begin
        state_next = stbs_pkg::ST_IDLE;
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = stbs_pkg::ADDR_FIRST;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      stbs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = (command == stbs_pkg::CMD_SEARCH);
          cmd.write = (command == stbs_pkg::CMD_WRITE);
        end
      end
      stbs_pkg::ST_CHK_FIRST: begin
        cmd.addr_sel = stbs_pkg::ADDR_LAST;
      end
      stbs_pkg::ST_CHK_LAST: begin
        cmd.init_bounds = 1'b1;
        cmd.addr_sel    = stbs_pkg::ADDR_INIT_MID;
      end
      stbs_pkg::ST_PROBE: begin
        cmd.probe    = 1'b1;
        cmd.addr_sel = stbs_pkg::ADDR_NEXT_MID;
      end
      stbs_pkg::ST_DONE: begin
        result_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // a result strobe lasts one cycle and is followed by idle
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !busy)
    else $error("result strobe not followed by idle");

  // bound init and probe commands are issued only while searching, not with the result strobe
  a_probe_only_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe || cmd.init_bounds) |-> busy && !result_valid)
    else $error("search step issued outside a search");

endmodule

// ----- hw/rtl/stbs_dp.sv -----
// datapath for the sorted table search: table memory, bounds and compare
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   config_write,
  input  logic [10:0]            config_data,
  input  logic [9:0]             entry_index,
  input  logic signed [31:0]     value,
  input  stbs_pkg::stbs_cmd_t     cmd,
  output stbs_pkg::stbs_status_t  status,
  output logic                   found,
  output logic [9:0]             match_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [31:0] mem [TABLE_DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_in_range;

  logic [10:0]        count_reg;
  logic signed [31:0] key;
  logic [CW-1:0]      n;
  logic [CW-1:0]      n_sat;
  logic [CW-1:0]      first;
  logic [CW-1:0]      last;
  logic [CW-1:0]      mid;
  logic               hit_eq;

  logic [CW-1:0]      first_next;
  logic [CW-1:0]      last_next;
  logic [CW-1:0]      mid_next;
  logic               hit_eq_next;
  logic               key_le;

  assign wr_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign n_sat = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_reg);
  assign key_le = key <= rd_data;

  // one halving step on the data of the current probe
  always_comb begin
    first_next  = first;
    last_next   = last;
    hit_eq_next = hit_eq;
    if (key_le) begin
      last_next   = mid;
      hit_eq_next = (key == rd_data);
    end else begin
      first_next = mid + CW'(1);
    end
    mid_next = first_next + ((last_next - first_next) >> 1);
  end

  always_comb begin
    case (cmd.addr_sel)
      stbs_pkg::ADDR_FIRST:    rd_addr = '0;
      stbs_pkg::ADDR_LAST:     rd_addr = AW'(n - CW'(1));
      stbs_pkg::ADDR_INIT_MID: rd_addr = AW'(n >> 1);
      stbs_pkg::ADDR_NEXT_MID: rd_addr = AW'(mid_next);
      default:                 rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_in_range) begin
      mem[AW'(entry_index)] <= value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (config_write) begin
      count_reg <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key    <= value;
      n      <= n_sat;
      hit_eq <= 1'b0;
    end
    if (cmd.init_bounds) begin
      first <= '0;
      last  <= n;
      mid   <= n >> 1;
    end
    if (cmd.probe) begin
      first  <= first_next;
      last   <= last_next;
      mid    <= mid_next;
      hit_eq <= hit_eq_next;
    end
  end

  assign status.count_zero  = (n_sat == '0);
  assign status.key_ge_data = key >= rd_data;
  assign status.key_le_data = key_le;
  assign status.more        = first_next < last_next;

  assign found       = hit_eq;
  assign match_index = hit_eq ? 10'(32'(last)) : 10'd0;

  // the probe always lies inside the half-open search range
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> (mid >= first) && (mid < last) && (last <= n))
    else $error("probe outside search range");

  // a new search starts with no hit
  a_load_clears_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !hit_eq)
    else $error("hit flag not cleared at search start");

  // a hit always points inside the entries in use
  a_hit_in_use: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe && hit_eq) |-> last < n)
    else $error("hit index beyond entries in use");

endmodule
